FILE: design/cleb_pkg.sv
// Package for the console line edit buffer: command and result types,
// operation codes, key codes and status codes. No dependencies.
`timescale 1ns / 1ps

package cleb_pkg;

    // Operations as classified by the front end
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_DUMP  = 3'd1;
    localparam logic [2:0] OP_KILL  = 3'd2;
    localparam logic [2:0] OP_ERASE = 3'd3;
    localparam logic [2:0] OP_STORE = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_CTRL_P = 8'h10;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_DEL    = 8'h7F;

    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_CHAR  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;

    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_CHAR  = 2'd1;
    localparam logic [1:0] RD_EMPTY = 2'd2;
    localparam logic [1:0] RD_EOF   = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] chr;
        logic       started;
    } cmd_t;

    typedef struct packed {
        logic [1:0] echo_kind;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       wake_reader;
        logic       dump_request;
        logic [1:0] read_status;
        logic [7:0] read_char;
        logic       read_done;
    } res_t;

endpackage

FILE: design/cleb_front.sv
// Front end of the console line edit buffer: accepts items, classifies them
// into commands and holds them in a two-entry queue. Depends on cleb_pkg.
`timescale 1ns / 1ps

module cleb_front
    import cleb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_func,
    input  logic [7:0] in_key_code,
    input  logic       in_read_started,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_pop
);

    localparam int QUEUE_DEPTH = 2;

    cmd_t       q_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cmd_in;
    logic       push;
    logic       pop;

    always_comb begin
        cmd_in.chr     = in_key_code;
        cmd_in.started = in_read_started;
        if (in_func) begin
            cmd_in.op = OP_READ;
        end else begin
            case (in_key_code)
                KEY_NUL:             cmd_in.op = OP_NOP;
                KEY_CTRL_P:          cmd_in.op = OP_DUMP;
                KEY_CTRL_U:          cmd_in.op = OP_KILL;
                KEY_CTRL_H, KEY_DEL: cmd_in.op = OP_ERASE;
                KEY_CR: begin
                    cmd_in.op  = OP_STORE;
                    cmd_in.chr = KEY_LF;
                end
                default:             cmd_in.op = OP_STORE;
            endcase
        end
    end

    assign in_ready  = (count_reg != 2'(QUEUE_DEPTH));
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: design/cleb_back.sv
// Back end of the console line edit buffer: the line store, the read,
// commit and edit pointers, the command sequencer and the result register.
// Depends on cleb_pkg.
`timescale 1ns / 1ps

module cleb_back
    import cleb_pkg::*;
#(
    parameter int BUF_DEPTH = 128
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic res_valid,
    output res_t res,
    input  logic res_ready
);

    localparam int AW    = $clog2(BUF_DEPTH);
    localparam int SPAN  = 2 * BUF_DEPTH;
    localparam int PTR_W = $clog2(SPAN);

    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_READ_DATA = 2'd1;
    localparam logic [1:0] ST_KILL_RD   = 2'd2;
    localparam logic [1:0] ST_KILL_CHK  = 2'd3;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(SPAN - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(SPAN - 1) : p - PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] hi,
                                                  input logic [PTR_W-1:0] lo);
        logic [PTR_W:0] d;
        d = (hi >= lo) ? {1'b0, hi} - {1'b0, lo}
                       : (PTR_W+1)'(SPAN) + {1'b0, hi} - {1'b0, lo};
        return d[PTR_W-1:0];
    endfunction

    function automatic logic [AW-1:0] slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] t;
        t = (p >= PTR_W'(BUF_DEPTH)) ? p - PTR_W'(BUF_DEPTH) : p;
        return t[AW-1:0];
    endfunction

    logic [7:0]       mem [BUF_DEPTH];
    logic [7:0]       rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0] commit_ptr_reg, commit_ptr_next;
    logic [PTR_W-1:0] edit_ptr_reg, edit_ptr_next;
    logic             started_reg, started_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic             any_reg, any_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    logic             out_free;
    logic             load_out;
    logic [PTR_W-1:0] fill;

    assign out_free  = !res_valid_reg || res_ready;
    assign fill      = ptr_dist(edit_ptr_reg, read_ptr_reg);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        state_next      = state_reg;
        read_ptr_next   = read_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        edit_ptr_next   = edit_ptr_reg;
        started_next    = started_reg;
        cnt_next        = cnt_reg;
        any_next        = any_reg;
        res_next        = res_reg;
        load_out        = 1'b0;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = slot(edit_ptr_reg);
        mem_wdata       = cmd.chr;
        mem_re          = 1'b0;
        mem_raddr       = slot(read_ptr_reg);

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop  = 1'b1;
                    res_next = '0;
                    case (cmd.op)
                        OP_DUMP: begin
                            res_next.dump_request = 1'b1;
                            load_out = 1'b1;
                        end
                        OP_ERASE: begin
                            if (edit_ptr_reg != commit_ptr_reg) begin
                                edit_ptr_next        = ptr_dec(edit_ptr_reg);
                                res_next.echo_kind   = ECHO_ERASE;
                                res_next.erase_count = 8'd1;
                            end
                            load_out = 1'b1;
                        end
                        OP_STORE: begin
                            if (fill < PTR_W'(BUF_DEPTH)) begin
                                mem_we             = 1'b1;
                                edit_ptr_next      = ptr_inc(edit_ptr_reg);
                                res_next.echo_kind = ECHO_CHAR;
                                res_next.echo_char = cmd.chr;
                                if (cmd.chr == KEY_LF || cmd.chr == KEY_CTRL_D ||
                                    fill == PTR_W'(BUF_DEPTH - 1)) begin
                                    commit_ptr_next      = ptr_inc(edit_ptr_reg);
                                    res_next.wake_reader = 1'b1;
                                end
                            end
                            load_out = 1'b1;
                        end
                        OP_READ: begin
                            if (read_ptr_reg == commit_ptr_reg) begin
                                res_next.read_status = RD_EMPTY;
                                load_out = 1'b1;
                            end else begin
                                mem_re       = 1'b1;
                                started_next = cmd.started;
                                state_next   = ST_READ_DATA;
                            end
                        end
                        OP_KILL: begin
                            cnt_next   = 8'd0;
                            any_next   = 1'b0;
                            state_next = ST_KILL_RD;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_DATA: begin
                if (out_free) begin
                    res_next = '0;
                    if (rdata_reg == KEY_CTRL_D) begin
                        if (!started_reg) begin
                            read_ptr_next = ptr_inc(read_ptr_reg);
                        end
                        res_next.read_status = RD_EOF;
                        res_next.read_done   = 1'b1;
                    end else begin
                        read_ptr_next        = ptr_inc(read_ptr_reg);
                        res_next.read_status = RD_CHAR;
                        res_next.read_char   = rdata_reg;
                        res_next.read_done   = (rdata_reg == KEY_LF);
                    end
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_KILL_RD: begin
                if (edit_ptr_reg == commit_ptr_reg) begin
                    if (out_free) begin
                        res_next = '0;
                        if (any_reg) begin
                            res_next.echo_kind   = ECHO_ERASE;
                            res_next.erase_count = cnt_reg;
                        end
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = slot(ptr_dec(edit_ptr_reg));
                    state_next = ST_KILL_CHK;
                end
            end
            ST_KILL_CHK: begin
                if (rdata_reg == KEY_LF) begin
                    if (out_free) begin
                        res_next = '0;
                        if (any_reg) begin
                            res_next.echo_kind   = ECHO_ERASE;
                            res_next.erase_count = cnt_reg;
                        end
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    edit_ptr_next = ptr_dec(edit_ptr_reg);
                    cnt_next      = cnt_reg + 8'd1;
                    any_next      = 1'b1;
                    state_next    = ST_KILL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            read_ptr_reg   <= '0;
            commit_ptr_reg <= '0;
            edit_ptr_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            read_ptr_reg   <= read_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            edit_ptr_reg   <= edit_ptr_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        started_reg <= started_next;
        cnt_reg     <= cnt_next;
        any_reg     <= any_next;
        res_reg     <= res_next;
    end

    // Line store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

FILE: design/console_line_edit_buffer_unit.sv
// Top level of the console line edit buffer: stream ports, front end with
// command queue, and back end with line store. Depends on cleb_pkg,
// cleb_front and cleb_back.
`timescale 1ns / 1ps

// Keyboard line-editing buffer of a console. Each input transfer is either a
// keystroke (tuser 0) or a reader's request for one character (tuser 1), and
// yields exactly one result transfer. A two-entry command queue decouples the
// input side from the execution side. After the queue, and with the result
// side ready, a stored key, erase, ctrl-P, dropped key or read of an empty
// buffer is executed from the idle state, and a read that finds committed
// data passes through a data state because the line store has a registered
// read port. Ctrl-U walks back over the uncommitted characters until the
// commit point or a line feed; each step of the kill walk is a read of the
// line store followed by a compare. The line store has no reset; no clearing
// pass is needed after reset.
module console_line_edit_buffer_unit
    import cleb_pkg::*;
#(
    parameter int BUF_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // key_code[7:0], read_started[8], zero pad
    input  logic [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // echo_char[7:0], erase_count[15:8],
                                   // wake_reader[16], dump_request[17],
                                   // read_char[25:18], zero pad
    output logic [3:0]  m_tuser,   // echo_kind[1:0], read_status[3:2]
    output logic        m_tlast    // read_done
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    res_t res;

    cleb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_func         (s_tuser[0]),
        .in_key_code     (s_tdata[7:0]),
        .in_read_started (s_tdata[8]),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    cleb_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {6'd0, res.read_char, res.dump_request, res.wake_reader,
                      res.erase_count, res.echo_char};
    assign m_tuser = {res.read_status, res.echo_kind};
    assign m_tlast = res.read_done;

    // A result is either a keystroke result or a read result, never both.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:2] != RD_NONE |-> m_tuser[1:0] == ECHO_NONE &&
            !m_tdata[16] && !m_tdata[17])
        else $error("read result carries keystroke fields");

    // The end of a read comes only with a delivered character or end of file.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[3:2] == RD_CHAR || m_tuser[3:2] == RD_EOF)
        else $error("read_done without a character or end of file");

    // The echoed character is zero unless a character echo is requested.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != ECHO_CHAR |-> m_tdata[7:0] == 8'd0)
        else $error("echo_char set without a character echo");

    // The line is only committed by a stored key, which is always echoed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> m_tuser[1:0] == ECHO_CHAR)
        else $error("wake_reader without a stored key");

endmodule
